FILE: rtl/cgs_pkg.sv
`timescale 1ns / 1ps

package cgs_pkg;

    // largest half length of the boundary string
    localparam int MAX_SIZE   = 512;
    localparam int BITS_DEPTH = 2 * MAX_SIZE + 2;
    localparam int LIST_DEPTH = MAX_SIZE + 1;
    localparam int BIT_AW     = $clog2(BITS_DEPTH);
    localparam int LIST_AW    = $clog2(LIST_DEPTH);

    localparam logic [9:0] SIZE_RESET = 10'd512;
    localparam logic [9:0] SIZE_LIMIT = 10'(MAX_SIZE);

    // input command codes
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_GROW    = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_GROWN     = 2'd0;
    localparam logic [1:0] STAT_RESTARTED = 2'd1;
    localparam logic [1:0] STAT_BAD_PICK  = 2'd2;
    localparam logic [1:0] STAT_LIMIT     = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [9:0] pick;
    } cgs_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] grown_position;
        logic [9:0]  corner_count;
        logic [9:0]  low_edge;
        logic [10:0] high_edge;
        logic [9:0]  steps_done;
    } cgs_out_t;

    // controller to datapath
    typedef struct packed {
        logic init_list;
        logic take_in;
        logic decode;
        logic restart_wr;
        logic bits_rd;
        logic flip;
        logic app2;
        logic emit;
    } cgs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_restart;
        logic ignored;
        logic two_appends;
        logic out_free;
    } cgs_sts_t;

endpackage

FILE: rtl/cgs_ctrl.sv
`timescale 1ns / 1ps

module cgs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cgs_pkg::cgs_sts_t sts,
    output cgs_pkg::cgs_cmd_t cmd
);
    import cgs_pkg::*;

    typedef enum logic [7:0] {
        S_INIT    = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_DECODE  = 8'b0000_0100,
        S_RESTART = 8'b0000_1000,
        S_BITS    = 8'b0001_0000,
        S_FLIP    = 8'b0010_0000,
        S_APP2    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                if (sts.is_restart)   state_next = S_RESTART;
                else if (sts.ignored) state_next = S_DONE;
                else                  state_next = S_BITS;
            end
            S_RESTART: state_next = S_DONE;
            S_BITS:    state_next = S_FLIP;
            S_FLIP: begin
                state_next = sts.two_appends ? S_APP2 : S_DONE;
            end
            S_APP2: state_next = S_DONE;
            S_DONE: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign cmd.init_list  = (state_reg == S_INIT);
    assign cmd.take_in    = (state_reg == S_IDLE) && s_valid;
    assign cmd.decode     = (state_reg == S_DECODE);
    assign cmd.restart_wr = (state_reg == S_RESTART);
    assign cmd.bits_rd    = (state_reg == S_BITS);
    assign cmd.flip       = (state_reg == S_FLIP);
    assign cmd.app2       = (state_reg == S_APP2);
    assign cmd.emit       = (state_reg == S_DONE) && sts.out_free;

endmodule

FILE: rtl/cgs_datapath.sv
`timescale 1ns / 1ps

module cgs_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [9:0]        cfg_wr_data,
    input  cgs_pkg::cgs_in_t  s_data,
    output cgs_pkg::cgs_out_t m_data,
    output logic              m_valid,
    input  logic              m_ready,
    input  cgs_pkg::cgs_cmd_t cmd,
    output cgs_pkg::cgs_sts_t sts
);
    import cgs_pkg::*;

    // architectural state
    logic [9:0]  size_reg;
    logic [9:0]  n_reg;
    logic [9:0]  corners_reg;
    logic [9:0]  low_reg;
    logic [10:0] high_reg;
    logic [9:0]  step_reg;

    // per item working registers
    cgs_in_t     in_reg;
    logic [1:0]  status_reg;
    logic [10:0] grown_reg;
    logic [10:0] pos_reg;
    cgs_out_t    out_reg;
    logic        m_valid_reg;

    // memories and their registered read data
    logic [10:0] list_mem [LIST_DEPTH];
    logic        bit_mem  [BITS_DEPTH];
    logic [10:0] list_rd_a_reg;
    logic [10:0] list_rd_b_reg;
    logic        bit_lo_reg;
    logic        bit_hi_reg;

    logic               list_we;
    logic [LIST_AW-1:0] list_wa;
    logic [10:0]        list_wd;
    logic               bit_we;
    logic [BIT_AW-1:0]  bit_wa;
    logic               bit_wd;

    logic [9:0]  n_clamped;
    logic        step_limit;
    logic        pick_bad;
    logic [10:0] pos_m1;
    logic [11:0] pos_p2;
    logic [11:0] pos_p1;
    logic        lo_val;
    logic        hi_val;
    logic        left;
    logic        right;
    logic [9:0]  corners_next;

    // size 0 reads as 1, sizes above the maximum saturate
    always_comb begin
        if (size_reg == 10'd0)            n_clamped = 10'd1;
        else if (size_reg > SIZE_LIMIT)   n_clamped = SIZE_LIMIT;
        else                              n_clamped = size_reg;
    end

    assign step_limit = (step_reg >= n_reg);
    assign pick_bad   = (in_reg.pick >= corners_reg);

    assign sts.is_restart = (in_reg.cmd == CMD_RESTART);
    assign sts.ignored    = step_limit || pick_bad;
    assign sts.out_free   = !m_valid_reg || m_ready;

    // neighbor bits: at or below the low mark the string is still all ones,
    // above the high mark still all zeros; only the window between is stored
    assign pos_m1 = pos_reg - 11'd1;
    assign pos_p1 = {1'b0, pos_reg} + 12'd1;
    assign pos_p2 = {1'b0, pos_reg} + 12'd2;

    always_comb begin
        if (pos_m1 <= {1'b0, low_reg}) lo_val = 1'b1;
        else if (pos_m1 > high_reg)    lo_val = 1'b0;
        else                           lo_val = bit_lo_reg;
        if (pos_p2 <= {2'b0, low_reg})      hi_val = 1'b1;
        else if (pos_p2 > {1'b0, high_reg}) hi_val = 1'b0;
        else                                hi_val = bit_hi_reg;
    end

    assign left  = (pos_reg != 11'd0) && lo_val;
    assign right = (pos_p2 < 12'(BITS_DEPTH)) && !hi_val;
    assign sts.two_appends = left && right;

    assign corners_next = corners_reg - 10'd1 + {9'd0, left} + {9'd0, right};

    // list write port
    always_comb begin
        list_we = 1'b0;
        list_wa = '0;
        list_wd = '0;
        if (cmd.init_list || cmd.restart_wr) begin
            list_we = 1'b1;
            list_wa = '0;
            list_wd = {1'b0, n_reg};
        end else if (cmd.bits_rd) begin
            // swap with last: the last entry fills the picked slot
            list_we = 1'b1;
            list_wa = LIST_AW'(in_reg.pick);
            list_wd = list_rd_b_reg;
        end else if (cmd.flip) begin
            list_we = left || right;
            list_wa = LIST_AW'(corners_reg - 10'd1);
            list_wd = left ? pos_m1 : pos_p1[10:0];
        end else if (cmd.app2) begin
            list_we = 1'b1;
            list_wa = LIST_AW'(corners_reg - 10'd1);
            list_wd = pos_p1[10:0];
        end
    end

    // bit write port: pair i, i+1 goes from 1 0 to 0 1
    always_comb begin
        bit_we = 1'b0;
        bit_wa = '0;
        bit_wd = 1'b0;
        if (cmd.bits_rd) begin
            bit_we = (12'({1'b0, list_rd_a_reg}) + 12'd1) < 12'(BITS_DEPTH);
            bit_wa = BIT_AW'(list_rd_a_reg);
            bit_wd = 1'b0;
        end else if (cmd.flip) begin
            bit_we = pos_p1 < 12'(BITS_DEPTH);
            bit_wa = BIT_AW'(pos_p1);
            bit_wd = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (list_we) list_mem[list_wa] <= list_wd;
        if (cmd.decode) begin
            list_rd_a_reg <= list_mem[LIST_AW'(in_reg.pick)];
            list_rd_b_reg <= list_mem[LIST_AW'(corners_reg - 10'd1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (bit_we) bit_mem[bit_wa] <= bit_wd;
        if (cmd.bits_rd) begin
            bit_lo_reg <= bit_mem[BIT_AW'(list_rd_a_reg - 11'd1)];
            bit_hi_reg <= bit_mem[BIT_AW'(12'({1'b0, list_rd_a_reg}) + 12'd2)];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take_in) in_reg <= s_data;
        if (cmd.decode) begin
            grown_reg <= '0;
            if (in_reg.cmd == CMD_RESTART) status_reg <= STAT_RESTARTED;
            else if (step_limit)           status_reg <= STAT_LIMIT;
            else if (pick_bad)             status_reg <= STAT_BAD_PICK;
            else                           status_reg <= STAT_GROWN;
        end
        if (cmd.bits_rd) begin
            pos_reg   <= list_rd_a_reg;
            grown_reg <= list_rd_a_reg;
        end
        if (cmd.emit) begin
            out_reg.status         <= status_reg;
            out_reg.grown_position <= grown_reg;
            out_reg.corner_count   <= corners_reg;
            out_reg.low_edge       <= low_reg;
            out_reg.high_edge      <= high_reg;
            out_reg.steps_done     <= step_reg;
        end
    end

    // diagram state and handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= SIZE_RESET;
            n_reg       <= SIZE_LIMIT < SIZE_RESET ? SIZE_LIMIT : SIZE_RESET;
            corners_reg <= 10'd1;
            low_reg     <= SIZE_LIMIT < SIZE_RESET ? SIZE_LIMIT : SIZE_RESET;
            high_reg    <= {1'b0, (SIZE_LIMIT < SIZE_RESET ? SIZE_LIMIT : SIZE_RESET)};
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) size_reg <= cfg_wr_data;
            if (cmd.decode && in_reg.cmd == CMD_RESTART) begin
                n_reg       <= n_clamped;
                corners_reg <= 10'd1;
                low_reg     <= n_clamped;
                high_reg    <= {1'b0, n_clamped};
                step_reg    <= '0;
            end
            if (cmd.flip) begin
                corners_reg <= corners_next;
                if (pos_reg == {1'b0, low_reg} && low_reg != 10'd0) low_reg <= low_reg - 10'd1;
                if (pos_reg == high_reg) high_reg <= high_reg + 11'd1;
                step_reg <= step_reg + 10'd1;
            end
            if (cmd.emit)       m_valid_reg <= 1'b1;
            else if (m_ready)   m_valid_reg <= 1'b0;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/corner_growth_step.sv
`timescale 1ns / 1ps

// channel   ports                          carries
// --------  -----------------------------  --------------------------------------
// input     s_valid s_ready s_data         cmd (restart / grow), pick (list index)
// result    m_valid m_ready m_data         status, grown position, corner count,
//                                          low/high edge, steps done
// config    cfg_wr_en cfg_wr_data          size, written without wait
//
// a grow runs from transfer in to result valid: status with both list reads,
// boundary-bit reads with the swap write, flip with the first append, the second
// append if two corners are appended (single list write port), the result load;
// a restart runs status, entry-zero write, result load; an ignored item status,
// result load. s_ready returns the cycle after the result load. after reset the
// init state seeds corner list entry zero before s_ready rises. a waiting result
// does not block the next transfer in; only the result load waits on m_ready.

module corner_growth_step (
    input  logic              aclk,
    input  logic              aresetn,
    // config
    input  logic              cfg_wr_en,
    input  logic [9:0]        cfg_wr_data,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  cgs_pkg::cgs_in_t  s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output cgs_pkg::cgs_out_t m_data
);
    import cgs_pkg::*;

    // command strobes and status flags between the two halves
    cgs_cmd_t cmd;
    cgs_sts_t sts;

    // sequencer: one item at a time, one state per memory access step
    cgs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: corner list, boundary bit store, marks and result register
    cgs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

FILE: tb/corner_growth_step_test.sv
`timescale 1ns / 1ps

// shadow of the diagram state plus the queue of outcomes still owed by the block
class corner_growth_tracker;
    logic [9:0]  size_reg;
    logic [9:0]  latched_n;
    bit          bnd [cgs_pkg::BITS_DEPTH];
    logic [10:0] corner_pos [cgs_pkg::LIST_DEPTH];
    logic [9:0]  corners;
    logic [9:0]  low_mark;
    logic [10:0] high_mark;
    logic [9:0]  steps;
    cgs_pkg::cgs_out_t outcomes[$];
    int          failures;
    int          status_seen [4];

    function new();
        failures = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        size_reg = cgs_pkg::SIZE_RESET;
        rebuild();
    endfunction

    function void set_size(logic [9:0] v);
        size_reg = v;
    endfunction

    // empty diagram: ones up to n, zeros beyond, one corner at n
    function void rebuild();
        logic [9:0] n;
        n = size_reg;
        if (n < 10'd1) n = 10'd1;
        if (n > cgs_pkg::SIZE_LIMIT) n = cgs_pkg::SIZE_LIMIT;
        latched_n = n;
        foreach (bnd[k]) bnd[k] = (k <= n);
        foreach (corner_pos[k]) corner_pos[k] = '0;
        corner_pos[0] = 11'(n);
        corners   = 10'd1;
        low_mark  = n;
        high_mark = 11'(n);
        steps     = '0;
    endfunction

    function void add_corner(logic [10:0] pos);
        if (corners < cgs_pkg::LIST_DEPTH) begin
            corner_pos[corners] = pos;
            corners++;
        end
    endfunction

    function cgs_pkg::cgs_out_t grow_outcome(cgs_pkg::cgs_in_t it);
        cgs_pkg::cgs_out_t r;
        logic [10:0] pos;
        r.grown_position = '0;
        if (it.cmd == cgs_pkg::CMD_RESTART) begin
            rebuild();
            r.status = cgs_pkg::STAT_RESTARTED;
        end else if (steps >= latched_n) begin
            // limit test wins over the pick test
            r.status = cgs_pkg::STAT_LIMIT;
        end else if (it.pick >= corners) begin
            r.status = cgs_pkg::STAT_BAD_PICK;
        end else begin
            pos = corner_pos[it.pick];
            corners--;
            corner_pos[it.pick] = corner_pos[corners];
            if (pos + 1 < cgs_pkg::BITS_DEPTH) begin
                bnd[pos]     = 1'b0;
                bnd[pos + 1] = 1'b1;
            end
            if (pos == low_mark && low_mark > 0) low_mark--;
            if (pos == high_mark) high_mark++;
            if (pos >= 1 && bnd[pos - 1]) add_corner(pos - 11'd1);
            if (pos + 2 < cgs_pkg::BITS_DEPTH && !bnd[pos + 2]) add_corner(pos + 11'd1);
            steps++;
            r.grown_position = pos;
            r.status = cgs_pkg::STAT_GROWN;
        end
        r.corner_count = corners;
        r.low_edge     = low_mark;
        r.high_edge    = high_mark;
        r.steps_done   = steps;
        return r;
    endfunction

    function void note_item(cgs_pkg::cgs_in_t it);
        cgs_pkg::cgs_out_t r;
        r = grow_outcome(it);
        status_seen[r.status]++;
        outcomes.push_back(r);
    endfunction

    function void compare(string name, logic [10:0] want, logic [10:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(cgs_pkg::cgs_out_t got);
        cgs_pkg::cgs_out_t want;
        if (outcomes.size() == 0) begin
            $error("result transfer with no outcome outstanding");
            failures++;
            return;
        end
        want = outcomes.pop_front();
        compare("status", 11'(want.status), 11'(got.status));
        compare("grown_position", want.grown_position, got.grown_position);
        compare("corner_count", 11'(want.corner_count), 11'(got.corner_count));
        compare("low_edge", 11'(want.low_edge), 11'(got.low_edge));
        compare("high_edge", want.high_edge, got.high_edge);
        compare("steps_done", 11'(want.steps_done), 11'(got.steps_done));
    endfunction

    function int pending();
        return outcomes.size();
    endfunction
endclass

module corner_growth_step_test;
    import cgs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1700;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [9:0]        cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    cgs_pkg::cgs_in_t  s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    cgs_pkg::cgs_out_t m_data;

    corner_growth_tracker tracker;

    int cycle_count = 0;
    int items_sent  = 0;
    int size_writes = 0;
    int burst_left  = 0;
    int rx_mode     = 0;
    int rx_hold     = 0;

    corner_growth_step u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #4 aclk = ~aclk;

    // global watchdog on the cycle count
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_data);
        // stall pattern switches to a random mode whenever its hold counter runs out
        if (rx_hold == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_hold = $urandom_range(50, 300);
        end else begin
            rx_hold--;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;                            // no stalls
            1: m_ready <= ($urandom_range(0, 3) != 0);     // light stalls
            2: m_ready <= ($urandom_range(0, 3) == 0);     // heavy stalls
            default: m_ready <= ((cycle_count % 7) >= 3);  // periodic stall
        endcase
    end

    function automatic cgs_pkg::cgs_in_t make_item(logic cmd, logic [9:0] pick);
        cgs_pkg::cgs_in_t it;
        it.cmd  = cmd;
        it.pick = pick;
        return it;
    endfunction

    // one input transfer, with bursts and random gaps between them
    task automatic send_item(input cgs_pkg::cgs_in_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // transfer happened at this edge
        tracker.note_item(it);
        items_sent++;
        burst_left--;
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_size(input logic [9:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_size(v);
        size_writes++;
    endtask

    // restart under a new size, then a run of mostly legal grows
    task automatic run_phase(input logic [9:0] size_val, input int grow_budget);
        int r;
        logic [9:0] p;
        write_size(size_val);
        send_item(make_item(CMD_RESTART, 10'($urandom)));
        for (int k = 0; k < grow_budget; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_item(make_item(CMD_RESTART, 10'($urandom)));
            end else if (r < 12) begin
                // noise pick, mostly out of range
                send_item(make_item(CMD_GROW, 10'($urandom)));
            end else begin
                p = 10'($urandom_range(0, int'(tracker.corners) - 1));
                send_item(make_item(CMD_GROW, p));
            end
        end
    endtask

    initial begin
        int sel;
        int eff_n;
        logic [9:0] sz;
        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset-time diagram at full size, picks at the edge of range
        send_item(make_item(CMD_GROW, 10'd0));
        send_item(make_item(CMD_GROW, 10'd2));      // pick equal to corner count
        send_item(make_item(CMD_GROW, 10'd1023));
        send_item(make_item(CMD_GROW, 10'd1));
        send_item(make_item(CMD_RESTART, 10'd1023));

        // smallest size: step limit, and its precedence over a bad pick
        write_size(10'd1);
        send_item(make_item(CMD_RESTART, 10'd0));
        send_item(make_item(CMD_GROW, 10'd0));
        send_item(make_item(CMD_GROW, 10'd1023));
        send_item(make_item(CMD_GROW, 10'd0));

        // size zero clamps up to one
        write_size(10'd0);
        send_item(make_item(CMD_RESTART, 10'd0));
        send_item(make_item(CMD_GROW, 10'd0));
        send_item(make_item(CMD_GROW, 10'd0));

        // sizes above the maximum saturate
        write_size(10'd1023);
        send_item(make_item(CMD_RESTART, 10'd0));
        send_item(make_item(CMD_GROW, 10'd0));
        write_size(10'd513);
        send_item(make_item(CMD_RESTART, 10'd0));
        send_item(make_item(CMD_GROW, 10'd0));
        send_item(make_item(CMD_GROW, 10'd1));
        send_item(make_item(CMD_GROW, 10'd0));

        // size two: both neighbors appended, then the limit
        write_size(10'd2);
        send_item(make_item(CMD_RESTART, 10'd0));
        send_item(make_item(CMD_GROW, 10'd0));
        send_item(make_item(CMD_GROW, 10'd1));
        send_item(make_item(CMD_GROW, 10'd0));
        send_item(make_item(CMD_GROW, 10'd5));

        // one phase at the largest size with a grow budget above its step limit, then random phases
        run_phase(10'd512, 520);
        while (items_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 11);
            case (sel)
                0:       sz = 10'd0;
                1:       sz = 10'd1023;
                2:       sz = 10'd513;
                3:       sz = 10'd512;
                4, 5:    sz = 10'($urandom_range(49, 511));
                default: sz = 10'($urandom_range(1, 48));
            endcase
            eff_n = (sz == 0) ? 1 : ((sz > cgs_pkg::SIZE_LIMIT) ? cgs_pkg::MAX_SIZE : sz);
            if (eff_n <= 48)
                run_phase(sz, eff_n + $urandom_range(1, 6));
            else
                run_phase(sz, $urandom_range(30, 120));
        end

        wait_idle();
        repeat (20) @(posedge aclk);

        $display("ran %0d items over %0d size settings", items_sent, size_writes);
        $display("outcomes: %0d grown, %0d restarts, %0d bad picks, %0d at step limit",
                 tracker.status_seen[cgs_pkg::STAT_GROWN],
                 tracker.status_seen[cgs_pkg::STAT_RESTARTED],
                 tracker.status_seen[cgs_pkg::STAT_BAD_PICK],
                 tracker.status_seen[cgs_pkg::STAT_LIMIT]);
        if (tracker.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
